### hdl/gf16_matrix_vector_product_core_macros.svh
// Assertion macros shared by the GF(16) matrix-vector product RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef GF16_MATRIX_VECTOR_PRODUCT_CORE_MACROS_SVH
`define GF16_MATRIX_VECTOR_PRODUCT_CORE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define GF16MV_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gf16mv assertion failed");
// next-cycle implication
`define GF16MV_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gf16mv assertion failed");
`else
`define GF16MV_ASSERT_NOW(label, clk, rst, ante, cons)
`define GF16MV_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hdl/gf16mv_pkg.sv
// Package for the GF(16) matrix-vector product core: constants, register
// indexes, control struct and the nibble-wise GF(16) scaling functions.
`default_nettype none

package gf16mv_pkg;

   localparam int MAX_VECTOR_WORDS_DEFAULT = 512;
   localparam int MAX_COLUMNS_DEFAULT      = 128;

   localparam int WORD_WIDTH      = 32;
   localparam int COEFF_WIDTH     = 4;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 10;
   localparam int COLUMN_REG_WIDTH = 8;

   localparam logic [CSR_DATA_WIDTH-1:0]   RST_VECTOR_WORDS = 10'd512;
   localparam logic [COLUMN_REG_WIDTH-1:0] RST_COLUMN_COUNT = 8'd96;

   localparam logic [WORD_WIDTH-1:0]  NIB_TOP  = 32'h8888_8888;
   localparam logic [COEFF_WIDTH-1:0] NIB_MASK = 4'hf;

   // result queue between the accumulator stage and the result channel
   localparam int RSP_FIFO_DEPTH = 4;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_VECTOR_WORDS = 4'd0,
      CSR_COLUMN_COUNT = 4'd1
   } csr_reg_type;

   typedef struct packed {
      logic first_col;
      logic last_col;
      logic last_word;
   } seq_pos_type;

   // Multiply every nibble by x, reduction x^4 = x + 1.
   function automatic logic [WORD_WIDTH-1:0] nib_times_x(input logic [WORD_WIDTH-1:0] w);
      logic [WORD_WIDTH-1:0] top;
      logic [WORD_WIDTH-1:0] fold;
      top  = w & NIB_TOP;
      fold = top >> 3;
      return ((w ^ top) << 1) ^ fold ^ (fold << 1);
   endfunction

   // Multiply every nibble by the GF(16) element k.
   function automatic logic [WORD_WIDTH-1:0] nib_scale(input logic [WORD_WIDTH-1:0] w,
                                                       input logic [COEFF_WIDTH-1:0] k);
      logic [WORD_WIDTH-1:0] r;
      logic [WORD_WIDTH-1:0] p;
      r = '0;
      p = w;
      for (int b = 0; b < COEFF_WIDTH; b++) begin
         if (k[b]) begin
            r = r ^ p;
         end
         p = nib_times_x(p);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hdl/gf16mv_if.sv
// Valid/ready channel interfaces of the GF(16) matrix-vector product core.
// Depends on gf16mv_pkg for payload widths.
`default_nettype none

interface gf16mv_req_if;
   logic                                   valid;
   logic                                   ready;
   logic [gf16mv_pkg::WORD_WIDTH-1:0]      matrix_word;
   logic [gf16mv_pkg::COEFF_WIDTH-1:0]     column_coeff;
   modport source (output valid, output matrix_word, output column_coeff, input ready);
   modport sink   (input valid, input matrix_word, input column_coeff, output ready);
endinterface

interface gf16mv_rsp_if;
   logic                                   valid;
   logic                                   ready;
   logic [gf16mv_pkg::WORD_WIDTH-1:0]      product_word;
   logic                                   last_word;
   modport source (output valid, output product_word, output last_word, input ready);
   modport sink   (input valid, input product_word, input last_word, output ready);
endinterface

interface gf16mv_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [gf16mv_pkg::CSR_INDEX_WIDTH-1:0] index;
   logic [gf16mv_pkg::CSR_DATA_WIDTH-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### hdl/gf16mv_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same entry returns the old contents.
`default_nettype none

module gf16mv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hdl/gf16mv_seq.sv
// Register file and word/column sequencer of the GF(16) matrix-vector core.
// Depends on gf16mv_pkg, gf16mv_if and the assertion macro header.
`default_nettype none
`include "gf16_matrix_vector_product_core_macros.svh"

module gf16mv_seq #(
   parameter int MAX_VECTOR_WORDS = gf16mv_pkg::MAX_VECTOR_WORDS_DEFAULT,
   parameter int MAX_COLUMNS      = gf16mv_pkg::MAX_COLUMNS_DEFAULT,
   localparam int AW = (MAX_VECTOR_WORDS > 1) ? $clog2(MAX_VECTOR_WORDS) : 1,
   localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   gf16mv_csr_if.sink                 csr_ch,
   input  wire logic                  advance,
   output logic [AW-1:0]              word_idx,
   output gf16mv_pkg::seq_pos_type    pos
);

   // clamp to 1..max and return the last index
   function automatic logic [AW-1:0] last_word_of(input logic [gf16mv_pkg::CSR_DATA_WIDTH-1:0] v);
      int n;
      n = int'(v);
      if (n == 0) n = 1;
      if (n > MAX_VECTOR_WORDS) n = MAX_VECTOR_WORDS;
      return AW'(n - 1);
   endfunction

   function automatic logic [CW-1:0] last_col_of(input logic [gf16mv_pkg::COLUMN_REG_WIDTH-1:0] v);
      int n;
      n = int'(v);
      if (n == 0) n = 1;
      if (n > MAX_COLUMNS) n = MAX_COLUMNS;
      return CW'(n - 1);
   endfunction

   logic [AW-1:0] last_word_idx_ff, last_word_idx_in;
   logic [CW-1:0] last_col_idx_ff, last_col_idx_in;
   logic [AW-1:0] word_idx_ff, word_idx_in;
   logic [CW-1:0] col_idx_ff, col_idx_in;
   logic          csr_write;
   logic          at_last_word;
   logic          at_last_col;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid && csr_ch.ready;
   assign at_last_word = (word_idx_ff == last_word_idx_ff);
   assign at_last_col  = (col_idx_ff == last_col_idx_ff);

   always_comb begin
      last_word_idx_in = last_word_idx_ff;
      last_col_idx_in  = last_col_idx_ff;
      word_idx_in      = word_idx_ff;
      col_idx_in       = col_idx_ff;
      if (csr_write) begin
         unique case (gf16mv_pkg::csr_reg_type'(csr_ch.index))
            gf16mv_pkg::CSR_VECTOR_WORDS: begin
               last_word_idx_in = last_word_of(csr_ch.data);
               word_idx_in      = '0;
               col_idx_in       = '0;
            end
            gf16mv_pkg::CSR_COLUMN_COUNT: begin
               last_col_idx_in = last_col_of(csr_ch.data[gf16mv_pkg::COLUMN_REG_WIDTH-1:0]);
               word_idx_in     = '0;
               col_idx_in      = '0;
            end
            default: begin
               // unknown index: drop the write
            end
         endcase
      end else if (advance) begin
         if (at_last_word) begin
            word_idx_in = '0;
            col_idx_in  = at_last_col ? '0 : col_idx_ff + 1'b1;
         end else begin
            word_idx_in = word_idx_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_word_idx_ff <= last_word_of(gf16mv_pkg::RST_VECTOR_WORDS);
         last_col_idx_ff  <= last_col_of(gf16mv_pkg::RST_COLUMN_COUNT);
         word_idx_ff      <= '0;
         col_idx_ff       <= '0;
      end else begin
         last_word_idx_ff <= last_word_idx_in;
         last_col_idx_ff  <= last_col_idx_in;
         word_idx_ff      <= word_idx_in;
         col_idx_ff       <= col_idx_in;
      end
   end

   assign word_idx      = word_idx_ff;
   assign pos.first_col = (col_idx_ff == '0);
   assign pos.last_col  = at_last_col;
   assign pos.last_word = at_last_word;

   `GF16MV_ASSERT_NEXT(a_seq_word_bound, clock, reset, 1'b1, word_idx_ff <= last_word_idx_ff)
   `GF16MV_ASSERT_NEXT(a_seq_col_bound, clock, reset, 1'b1, col_idx_ff <= last_col_idx_ff)
   `GF16MV_ASSERT_NEXT(a_seq_idle, clock, reset, !csr_write && !advance, $stable(word_idx_ff))

endmodule

`default_nettype wire

### hdl/gf16_matrix_vector_product_core.sv
// Ports and usage: one matrix word enters per clock. Each word is scaled
// nibble-wise in GF(16) by its column coefficient while the accumulator RAM
// is read at the word index; the next cycle, the scaled word is written, or
// XORed with the stored word, back to the same entry. A write and a read of
// the same entry in one cycle (single-word vectors) are covered by a
// forwarding register. Result words of the last column pass through a
// four-entry queue, so the input stalls only when that queue, counting the
// word still in the accumulate stage, holds four words; any
// column other than the last never stalls. A result word passes from the
// accumulate stage into the queue. The accumulator needs no clearing after
// reset: the first column writes every entry before it is read. Writing
// either register restarts the product at word 0 of column 0.
// Depends on gf16mv_pkg, gf16mv_if, gf16mv_ram, gf16mv_seq and the macros.
`default_nettype none
`include "gf16_matrix_vector_product_core_macros.svh"

module gf16_matrix_vector_product_core #(
   parameter int MAX_VECTOR_WORDS = gf16mv_pkg::MAX_VECTOR_WORDS_DEFAULT,
   parameter int MAX_COLUMNS      = gf16mv_pkg::MAX_COLUMNS_DEFAULT
) (
   input  wire logic     clock,
   input  wire logic     reset,
   gf16mv_req_if.sink    req_ch,
   gf16mv_rsp_if.source  rsp_ch,
   gf16mv_csr_if.sink    csr_ch
);

   localparam int AW = (MAX_VECTOR_WORDS > 1) ? $clog2(MAX_VECTOR_WORDS) : 1;
   localparam int WW = gf16mv_pkg::WORD_WIDTH;
   localparam int FD = gf16mv_pkg::RSP_FIFO_DEPTH;
   localparam int FPW = $clog2(FD);
   localparam int FCW = $clog2(FD + 1);

   logic [AW-1:0]           word_idx;
   gf16mv_pkg::seq_pos_type pos;
   logic                    req_accept;
   logic [WW-1:0]           scaled;

   // accumulate stage
   logic                    s1_valid_ff;
   logic [AW-1:0]           s1_addr_ff;
   logic [WW-1:0]           s1_scaled_ff;
   gf16mv_pkg::seq_pos_type s1_pos_ff;
   logic [WW-1:0]           ram_rd_data;
   logic [WW-1:0]           acc_old;
   logic [WW-1:0]           acc_new;

   // forwarding of the write issued at the edge of the stage's read
   logic                    fwd_valid_ff;
   logic [AW-1:0]           fwd_addr_ff;
   logic [WW-1:0]           fwd_data_ff;

   // result queue
   logic [WW-1:0]           fifo_word_ff [FD];
   logic                    fifo_last_ff [FD];
   logic [FPW-1:0]          fifo_wr_ptr_ff;
   logic [FPW-1:0]          fifo_rd_ptr_ff;
   logic [FCW-1:0]          fifo_cnt_ff, fifo_cnt_in;
   logic                    fifo_push;
   logic                    fifo_pop;
   logic                    s1_pend;
   logic [FCW-1:0]          occupancy;

   gf16mv_seq #(
      .MAX_VECTOR_WORDS (MAX_VECTOR_WORDS),
      .MAX_COLUMNS      (MAX_COLUMNS)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .csr_ch   (csr_ch),
      .advance  (req_accept),
      .word_idx (word_idx),
      .pos      (pos)
   );

   // hold input in the last column while the queue could overflow
   assign s1_pend      = s1_valid_ff && s1_pos_ff.last_col;
   assign occupancy    = fifo_cnt_ff + FCW'(s1_pend);
   assign req_ch.ready = !pos.last_col || (occupancy < FCW'(FD));
   assign req_accept   = req_ch.valid && req_ch.ready;

   assign scaled = gf16mv_pkg::nib_scale(req_ch.matrix_word,
                                         req_ch.column_coeff & gf16mv_pkg::NIB_MASK);

   gf16mv_ram #(
      .WIDTH (WW),
      .DEPTH (MAX_VECTOR_WORDS)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (acc_new),
      .rd_en   (req_accept),
      .rd_addr (word_idx),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      acc_old = (fwd_valid_ff && (fwd_addr_ff == s1_addr_ff)) ? fwd_data_ff : ram_rd_data;
      acc_new = s1_pos_ff.first_col ? s1_scaled_ff : (acc_old ^ s1_scaled_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= req_accept;
         fwd_valid_ff <= s1_valid_ff;
      end
      if (req_accept) begin
         s1_addr_ff   <= word_idx;
         s1_scaled_ff <= scaled;
         s1_pos_ff    <= pos;
      end
      fwd_addr_ff <= s1_addr_ff;
      fwd_data_ff <= acc_new;
   end

   assign fifo_push = s1_pend;
   assign fifo_pop  = rsp_ch.valid && rsp_ch.ready;

   always_comb begin
      fifo_cnt_in = fifo_cnt_ff;
      unique case ({fifo_push, fifo_pop})
         2'b10:   fifo_cnt_in = fifo_cnt_ff + 1'b1;
         2'b01:   fifo_cnt_in = fifo_cnt_ff - 1'b1;
         default: fifo_cnt_in = fifo_cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wr_ptr_ff <= '0;
         fifo_rd_ptr_ff <= '0;
         fifo_cnt_ff    <= '0;
      end else begin
         fifo_cnt_ff <= fifo_cnt_in;
         if (fifo_push) begin
            fifo_wr_ptr_ff <= fifo_wr_ptr_ff + 1'b1;
         end
         if (fifo_pop) begin
            fifo_rd_ptr_ff <= fifo_rd_ptr_ff + 1'b1;
         end
      end
      if (fifo_push) begin
         fifo_word_ff[fifo_wr_ptr_ff] <= acc_new;
         fifo_last_ff[fifo_wr_ptr_ff] <= s1_pos_ff.last_word;
      end
   end

   assign rsp_ch.valid        = (fifo_cnt_ff != '0);
   assign rsp_ch.product_word = fifo_word_ff[fifo_rd_ptr_ff];
   assign rsp_ch.last_word    = fifo_last_ff[fifo_rd_ptr_ff];

   `GF16MV_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, occupancy <= FCW'(FD))
   `GF16MV_ASSERT_NEXT(a_write_follows_accept, clock, reset, req_accept, s1_valid_ff)
   `GF16MV_ASSERT_NEXT(a_no_result_mid_column, clock, reset,
      s1_valid_ff && !s1_pos_ff.last_col && !fifo_pop, fifo_cnt_ff == $past(fifo_cnt_ff))

endmodule

`default_nettype wire
